// ===== hw/rtl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper with scanline IRQ.
package cbm_pkg;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   // Write decode on {address bits 15:12, folded bits 1:0}
   localparam logic [5:0] WR_PRG_FIRST  = 6'h20;
   localparam logic [5:0] WR_MIRROR     = 6'h24;
   localparam logic [5:0] WR_SWAP       = 6'h25;
   localparam logic [5:0] WR_PRG_SECOND = 6'h28;
   localparam logic [5:0] WR_CNT_LO     = 6'h3C;
   localparam logic [5:0] WR_ACK_A      = 6'h3D;
   localparam logic [5:0] WR_CNT_HI     = 6'h3E;
   localparam logic [5:0] WR_ACK_B      = 6'h3F;

   localparam logic [3:0] CHR_NIB_FIRST = 4'hB;
   localparam logic [3:0] CHR_NIB_LAST  = 4'hE;
   localparam logic [4:0] CHR_IDX_BIAS  = 5'd6;

   localparam logic [7:0] IRQ_FIRE_COUNT = 8'd237;
   localparam logic [7:0] ACK_STEP       = 8'd8;

   localparam logic [7:0] PRG_SECOND_LAST = 8'd254;
   localparam logic [7:0] PRG_LAST        = 8'd255;

   localparam logic [1:0] WIN_8000 = 2'd0;
   localparam logic [1:0] WIN_A000 = 2'd1;
   localparam logic [1:0] WIN_C000 = 2'd2;
   localparam logic [1:0] WIN_E000 = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] cpu_addr;
      logic [7:0]  write_data;
      logic        in_visible;
      logic [12:0] ppu_addr;
   } cbm_item_type;

   typedef struct packed {
      logic [7:0]      prg_first;
      logic [7:0]      prg_second;
      logic            mirror_bit;
      logic [1:0]      swap_mode;
      logic [7:0][7:0] char_banks;
      logic            irq_line;
   } cbm_view_type;

endpackage

// ===== hw/rtl/cbm_req_if.sv =====
// Request channel: command item with valid/ready handshake.
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] cpu_addr;
   logic [7:0]  write_data;
   logic        in_visible;
   logic [12:0] ppu_addr;

   modport source (output valid, command, cpu_addr, write_data, in_visible, ppu_addr,
                   input ready);
   modport sink   (input valid, command, cpu_addr, write_data, in_visible, ppu_addr,
                   output ready);
endinterface

// ===== hw/rtl/cbm_rsp_if.sv =====
// Response channel: bank lookup result with valid/ready handshake.
interface cbm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] prg_bank;
   logic [7:0] chr_bank;
   logic       mirroring;
   logic       irq;

   modport source (output valid, prg_bank, chr_bank, mirroring, irq, input ready);
   modport sink   (input valid, prg_bank, chr_bank, mirroring, irq, output ready);
endinterface

// ===== hw/rtl/cbm_state.sv =====
// Mapper register file: write decode, IRQ counter and the updated register view.
module cbm_state
   import cbm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         apply,
   input  cbm_item_type item,
   output cbm_view_type view
);

   logic [7:0]      prg_first_ff, prg_first_in;
   logic [7:0]      prg_second_ff, prg_second_in;
   logic            mirror_bit_ff, mirror_bit_in;
   logic [1:0]      swap_mode_ff, swap_mode_in;
   logic [7:0][7:0] char_banks_ff, char_banks_in;
   logic [7:0]      irq_counter_ff, irq_counter_in;
   logic            irq_enable_ff, irq_enable_in;
   logic            irq_line_ff, irq_line_in;

   logic [3:0] nib;
   logic [1:0] low_bits;
   logic [5:0] wr_code;
   logic [4:0] idx_wide;
   logic [2:0] chr_idx;
   logic       is_write;
   logic       is_tick;
   logic       chr_hit;
   logic       ack;

   // address scramble: bits 3:2 fold onto bits 1:0
   assign nib      = item.cpu_addr[15:12];
   assign low_bits = item.cpu_addr[1:0] | item.cpu_addr[3:2];
   assign wr_code  = {nib, low_bits};
   assign idx_wide = {nib, 1'b0} - CHR_IDX_BIAS;
   assign chr_idx  = idx_wide[2:0] | {2'b00, low_bits[0]};
   assign is_write = apply && (item.command == CMD_WRITE) && item.cpu_addr[15];
   assign is_tick  = apply && (item.command == CMD_TICK);
   assign chr_hit  = (nib >= CHR_NIB_FIRST) && (nib <= CHR_NIB_LAST);
   assign ack      = is_write && !chr_hit && ((wr_code == WR_ACK_A) || (wr_code == WR_ACK_B));

   always_comb begin
      prg_first_in   = prg_first_ff;
      prg_second_in  = prg_second_ff;
      mirror_bit_in  = mirror_bit_ff;
      swap_mode_in   = swap_mode_ff;
      char_banks_in  = char_banks_ff;
      irq_counter_in = irq_counter_ff;
      irq_enable_in  = irq_enable_ff;
      irq_line_in    = irq_line_ff;
      if (is_write) begin
         if (chr_hit) begin
            if (low_bits[1]) begin
               char_banks_in[chr_idx][7:4] = item.write_data[3:0];
            end else begin
               char_banks_in[chr_idx][3:0] = item.write_data[3:0];
            end
         end else begin
            unique case (wr_code)
               WR_PRG_FIRST:  prg_first_in = item.write_data;
               WR_PRG_SECOND: prg_second_in = item.write_data;
               WR_MIRROR:     mirror_bit_in = item.write_data[0];
               WR_SWAP:       swap_mode_in = item.write_data[1:0];
               WR_CNT_LO:     irq_counter_in[3:0] = item.write_data[3:0];
               WR_CNT_HI:     irq_counter_in[7:4] = item.write_data[3:0];
               WR_ACK_A, WR_ACK_B: begin
                  irq_enable_in = item.write_data[1];
                  irq_line_in   = 1'b0;
                  if (item.in_visible) begin
                     irq_counter_in = irq_counter_ff - ACK_STEP;
                  end
               end
               default: ;
            endcase
         end
      end else if (is_tick && irq_enable_ff) begin
         irq_counter_in = irq_counter_ff + 8'd1;
         if (irq_counter_in == IRQ_FIRE_COUNT) begin
            irq_line_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_first_ff   <= '0;
         prg_second_ff  <= '0;
         mirror_bit_ff  <= 1'b0;
         swap_mode_ff   <= '0;
         char_banks_ff  <= '0;
         irq_counter_ff <= '0;
         irq_enable_ff  <= 1'b0;
         irq_line_ff    <= 1'b0;
      end else begin
         prg_first_ff   <= prg_first_in;
         prg_second_ff  <= prg_second_in;
         mirror_bit_ff  <= mirror_bit_in;
         swap_mode_ff   <= swap_mode_in;
         char_banks_ff  <= char_banks_in;
         irq_counter_ff <= irq_counter_in;
         irq_enable_ff  <= irq_enable_in;
         irq_line_ff    <= irq_line_in;
      end
   end

   assign view.prg_first  = prg_first_in;
   assign view.prg_second = prg_second_in;
   assign view.mirror_bit = mirror_bit_in;
   assign view.swap_mode  = swap_mode_in;
   assign view.char_banks = char_banks_in;
   assign view.irq_line   = irq_line_in;

   a_irq_rise_on_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_line_ff) |-> $past(is_tick))
      else $error("irq line rose without a scanline tick");

   a_irq_rise_count: assert property (@(posedge clock) disable iff (reset)
      $rose(irq_line_ff) |-> (irq_counter_ff == IRQ_FIRE_COUNT))
      else $error("irq line rose away from the fire count");

   a_ack_clears: assert property (@(posedge clock) disable iff (reset)
      ack |=> !irq_line_ff)
      else $error("acknowledge did not clear the irq line");

   a_counter_idle: assert property (@(posedge clock) disable iff (reset)
      !apply |=> $stable(irq_counter_ff) && $stable(irq_line_ff))
      else $error("irq state changed without a transfer");

endmodule

// ===== hw/rtl/cartridge_bank_mapper_irq_core.sv =====
// Top level of the cartridge bank mapper with scanline IRQ counter.
// Each request transfer is captured in an input register; once the output register is free or
// being taken, it is applied to the mapper registers and looked up, and its response is held
// in the output register. One request transfer is accepted every cycle while the response
// side does not stall; a stalled response side fills the output and input registers before
// req_chan.ready drops.
module cartridge_bank_mapper_irq_core
   import cbm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_chan,
   cbm_rsp_if.source rsp_chan
);

   logic         in_valid_ff, in_valid_in;
   cbm_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   prg_bank_ff, prg_bank_in;
   logic [7:0]   chr_bank_ff, chr_bank_in;
   logic         mirroring_ff, mirroring_in;
   logic         irq_ff, irq_in;

   cbm_item_type req_item;
   cbm_view_type view;
   logic         accept;
   logic         advance;
   logic         swapped;

   assign req_item.command    = req_chan.command;
   assign req_item.cpu_addr   = req_chan.cpu_addr;
   assign req_item.write_data = req_chan.write_data;
   assign req_item.in_visible = req_chan.in_visible;
   assign req_item.ppu_addr   = req_chan.ppu_addr;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   cbm_state u_state (
      .clock (clock),
      .reset (reset),
      .apply (advance),
      .item  (in_item_ff),
      .view  (view)
   );

   assign swapped = |view.swap_mode;

   always_comb begin
      unique case (in_item_ff.cpu_addr[14:13])
         WIN_8000: prg_bank_in = swapped ? PRG_SECOND_LAST : view.prg_first;
         WIN_A000: prg_bank_in = view.prg_second;
         WIN_C000: prg_bank_in = swapped ? view.prg_first : PRG_SECOND_LAST;
         WIN_E000: prg_bank_in = PRG_LAST;
         default:  prg_bank_in = PRG_LAST;
      endcase
   end

   assign chr_bank_in  = view.char_banks[in_item_ff.ppu_addr[12:10]];
   assign mirroring_in = ~view.mirror_bit;
   assign irq_in       = view.irq_line;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         prg_bank_ff  <= prg_bank_in;
         chr_bank_ff  <= chr_bank_in;
         mirroring_ff <= mirroring_in;
         irq_ff       <= irq_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.prg_bank  = prg_bank_ff;
   assign rsp_chan.chr_bank  = chr_bank_ff;
   assign rsp_chan.mirroring = mirroring_ff;
   assign rsp_chan.irq       = irq_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("pending response overwritten");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_chan.ready)
      else $error("input register accepts while occupied");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced transfer missing from output register");

endmodule
